### rtl/size_class_block_allocator_assert.svh
// Assertion macros used by the allocator back end.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH

// Checked outside reset.
`define SCBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SCBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/scba_pkg.sv
// Shared constants, types and codes of the size-class block allocator.
package scba_pkg;

  localparam int MAX_SMALL_CLASSES = 32;
  localparam int CLASS_COUNT       = MAX_SMALL_CLASSES + 1;
  localparam int REGION_BYTES      = 4096;
  localparam int MAX_BLOCK_BYTES   = 2048;
  localparam int POOL_BYTES        = CLASS_COUNT * REGION_BYTES;
  localparam int LINK_WORDS        = POOL_BYTES / 8;

  localparam int ADDR_W   = 18;
  localparam int SIZE_W   = 16;
  localparam int CFG_W    = 6;
  localparam int CLASS_W  = $clog2(CLASS_COUNT);
  localparam int OFFSET_W = $clog2(REGION_BYTES) + 1;
  localparam int SLOT_W   = $clog2(MAX_BLOCK_BYTES) + 1;
  localparam int REGION_W = $clog2(REGION_BYTES);
  localparam int WORD_W   = ADDR_W - 3;
  localparam int LINK_W   = ADDR_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] CLASS_COUNT_RESET = CFG_W'(8);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_BAD_ADDR  = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_FAIL
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [1:0]          status;
    logic [CLASS_W-1:0]  cls;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   addr;
  } queue_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_LINK
  } back_state_t;

endpackage

### rtl/scba_front.sv
// Front end: request intake, class register and size/address classification.
module scba_front import scba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                req_type,
  input  logic [SIZE_W-1:0]   req_size,
  input  logic [ADDR_W-1:0]   block_address,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                queue_full,
  output logic                push,
  output queue_entry_t        entry
);

  logic [CFG_W-1:0]   small_class_count;
  logic [CFG_W-1:0]   n_classes;
  logic [SIZE_W:0]    rounded;
  logic [SIZE_W:0]    small_limit;
  logic               size_bad;

  assign cfg_ready = 1'b1;
  assign busy      = queue_full;
  assign push      = start && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_class_count <= CLASS_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      small_class_count <= cfg_data;
    end
  end

  always_comb begin
    n_classes = (small_class_count > CFG_W'(MAX_SMALL_CLASSES)) ?
                CFG_W'(MAX_SMALL_CLASSES) : small_class_count;
    rounded     = ({1'b0, req_size} + (SIZE_W+1)'(7)) & ~(SIZE_W+1)'(7);
    small_limit = (SIZE_W+1)'({n_classes, 3'b000});
    size_bad    = (rounded == '0) || (rounded > (SIZE_W+1)'(MAX_BLOCK_BYTES));

    entry.op     = OP_FAIL;
    entry.status = ST_OK;
    entry.cls    = '0;
    entry.slot   = SLOT_W'(MAX_BLOCK_BYTES);
    entry.addr   = block_address;

    if (req_type == REQ_ALLOC) begin
      if (size_bad) begin
        entry.status = ST_BAD_SIZE;
      end else if (rounded > small_limit) begin
        entry.op  = OP_ALLOC;
        entry.cls = CLASS_W'(n_classes);
      end else begin
        entry.op   = OP_ALLOC;
        entry.cls  = CLASS_W'(rounded[SIZE_W:3] - (SIZE_W-2)'(1));
        entry.slot = rounded[SLOT_W-1:0];
      end
    end else begin
      if (block_address >= ADDR_W'(POOL_BYTES)) begin
        entry.status = ST_BAD_ADDR;
      end else begin
        entry.op  = OP_FREE;
        entry.cls = block_address[ADDR_W-1:REGION_W];
      end
    end
  end

endmodule

### rtl/scba_queue.sv
// Short request queue between the front end and the back end.
module scba_queue import scba_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  queue_entry_t  wr_entry,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output queue_entry_t  rd_entry
);

  queue_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

### rtl/scba_back.sv
// Back end: per-class offset/head state, link memory and result register.
`include "size_class_block_allocator_assert.svh"
module scba_back import scba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  queue_entry_t        head_entry,
  output logic                pop,
  output logic                done,
  output logic [1:0]          status,
  output logic [ADDR_W-1:0]   granted_address
);

  logic [OFFSET_W-1:0]  offset_mem [CLASS_COUNT];
  logic [ADDR_W-1:0]    head_mem   [CLASS_COUNT];
  logic [LINK_W-1:0]    link_mem   [LINK_WORDS];
  logic [CLASS_COUNT-1:0] off_valid;
  logic [CLASS_COUNT-1:0] list_nonempty;

  back_state_t          state;
  back_state_t          state_next;
  queue_entry_t         cur;
  logic [OFFSET_W-1:0]  off_rd;
  logic [ADDR_W-1:0]    head_rd;
  logic [LINK_W-1:0]    link_rd;

  logic                 rd_en;
  logic                 link_rd_en;
  logic                 link_we;
  logic                 off_we;
  logic                 head_we;
  logic [ADDR_W-1:0]    head_wdata;
  logic                 ne_we;
  logic                 ne_wdata;
  logic                 emit;
  logic [1:0]           emit_status;
  logic [ADDR_W-1:0]    emit_addr;
  logic [OFFSET_W-1:0]  cur_off;
  logic [OFFSET_W:0]    off_sum;

  assign cur_off = off_valid[cur.cls] ? off_rd : '0;
  assign off_sum = {1'b0, cur_off} + (OFFSET_W+1)'(cur.slot);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!empty && head_entry.op != OP_FAIL) begin
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (cur.op == OP_ALLOC && list_nonempty[cur.cls]) begin
          state_next = BK_LINK;
        end else begin
          state_next = BK_IDLE;
        end
      end
      BK_LINK: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    rd_en       = 1'b0;
    link_rd_en  = 1'b0;
    link_we     = 1'b0;
    off_we      = 1'b0;
    head_we     = 1'b0;
    head_wdata  = cur.addr;
    ne_we       = 1'b0;
    ne_wdata    = 1'b1;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_addr   = '0;
    case (state)
      BK_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (head_entry.op == OP_FAIL) begin
            emit        = 1'b1;
            emit_status = head_entry.status;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      BK_EXEC: begin
        if (cur.op == OP_FREE) begin
          link_we = 1'b1;
          head_we = 1'b1;
          ne_we   = 1'b1;
          emit    = 1'b1;
        end else if (list_nonempty[cur.cls]) begin
          link_rd_en = 1'b1;
        end else if (off_sum > (OFFSET_W+1)'(REGION_BYTES)) begin
          emit        = 1'b1;
          emit_status = ST_EXHAUSTED;
        end else begin
          off_we    = 1'b1;
          emit      = 1'b1;
          emit_addr = {cur.cls, cur_off[REGION_W-1:0]};
        end
      end
      BK_LINK: begin
        head_we    = 1'b1;
        head_wdata = link_rd[ADDR_W-1:0];
        ne_we      = 1'b1;
        ne_wdata   = link_rd[ADDR_W];
        emit       = 1'b1;
        emit_addr  = head_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      off_rd  <= offset_mem[head_entry.cls];
      head_rd <= head_mem[head_entry.cls];
    end
    if (off_we) begin
      offset_mem[cur.cls] <= off_sum[OFFSET_W-1:0];
    end
    if (head_we) begin
      head_mem[cur.cls] <= head_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (link_rd_en) begin
      link_rd <= link_mem[head_rd[ADDR_W-1:3]];
    end
    if (link_we) begin
      link_mem[cur.addr[ADDR_W-1:3]] <= {list_nonempty[cur.cls], head_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off_valid     <= '0;
      list_nonempty <= '0;
    end else begin
      if (off_we) begin
        off_valid[cur.cls] <= 1'b1;
      end
      if (ne_we) begin
        list_nonempty[cur.cls] <= ne_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status          <= emit_status;
      granted_address <= emit_addr;
    end
  end

  `SCBA_ASSERT(a_addr_zero_on_fail, done && status != ST_OK |-> granted_address == '0, "address on failed request")
  `SCBA_ASSERT(a_link_after_exec, state == BK_LINK |-> $past(state) == BK_EXEC, "link step out of order")
  `SCBA_ASSERT(a_exec_leaves, state == BK_EXEC |=> state == BK_IDLE || state == BK_LINK, "exec step stuck")
  `SCBA_ASSERT(a_no_pop_in_work, state != BK_IDLE |-> !pop, "queue popped mid request")

endmodule

### rtl/size_class_block_allocator.sv
// Top level of the size-class block allocator.
// Requests: drive req_type, req_size, block_address with start; a request is
//   taken at a clock edge where start is high and busy is low. busy rises only
//   while the two-entry request queue is full.
// Results: done is high for exactly one cycle with status and granted_address;
//   one result per request, in request order. The receiver cannot stall.
// Configuration: small_class_count on cfg_data, written when cfg_valid and
//   cfg_ready are high (cfg_ready is always high); write only while idle.
// Path from the accepting edge to done: the request passes the queue, then a
//   rejected request is answered from idle; a bump allocate, a failed allocate
//   or a free also passes exec; a free-list allocate passes exec and link.
// Back end: it handles one request at a time; a rejected request is done in the
//   idle state, other requests also pass the exec state, and a free-list pop
//   also the link state (extra link memory read). The per-class state memories
//   and the link memory read port set these steps.
// Reset: class count returns to 8 and every class region and free list is
//   empty at once (valid bits, no clearing pass); the queue is flushed.
module size_class_block_allocator import scba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                req_type,
  input  logic [SIZE_W-1:0]   req_size,
  input  logic [ADDR_W-1:0]   block_address,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic                done,
  output logic [1:0]          status,
  output logic [ADDR_W-1:0]   granted_address
);

  logic          queue_full;
  logic          queue_empty;
  logic          push;
  logic          pop;
  queue_entry_t  wr_entry;
  queue_entry_t  rd_entry;

  scba_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .req_size      (req_size),
    .block_address (block_address),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .queue_full    (queue_full),
    .push          (push),
    .entry         (wr_entry)
  );

  scba_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .rd_entry (rd_entry)
  );

  scba_back u_back (
    .clk             (clk),
    .rst             (rst),
    .empty           (queue_empty),
    .head_entry      (rd_entry),
    .pop             (pop),
    .done            (done),
    .status          (status),
    .granted_address (granted_address)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench for the size-class block allocator.
module testbench;
  import scba_pkg::*;

  localparam int TIMEOUT_CYCLES = 300000;
  localparam int PHASE_REQUESTS = 170;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } request_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
  } response_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              req_type = REQ_ALLOC;
  logic [SIZE_W-1:0] req_size = '0;
  logic [ADDR_W-1:0] block_address = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              done;
  logic [1:0]        status;
  logic [ADDR_W-1:0] granted_address;

  size_class_block_allocator u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .req_size        (req_size),
    .block_address   (block_address),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .done            (done),
    .status          (status),
    .granted_address (granted_address)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Allocator state mirror
  logic [CFG_W-1:0]  class_count_reg = CLASS_COUNT_RESET;
  int unsigned       region_fill [CLASS_COUNT] = '{default: 0};
  logic [ADDR_W-1:0] free_top [CLASS_COUNT] = '{default: '0};
  bit                free_valid [CLASS_COUNT] = '{default: 1'b0};
  bit [LINK_W-1:0]   link_word [LINK_WORDS];

  request_t          pending_requests [$];
  response_t         expected_responses [$];
  logic [ADDR_W-1:0] live_blocks [$];

  bit       req_fire = 1'b0;
  bit       no_gap_run = 1'b0;
  int       gap_left = 0;
  int       requests_queued = 0;
  int       requests_taken = 0;
  int       cfg_writes = 0;
  int       errors = 0;
  int       cycle_count = 0;
  int       n_grants = 0;
  int       n_frees = 0;
  int       n_bad_size = 0;
  int       n_exhausted = 0;
  int       n_bad_addr = 0;
  request_t next_req;

  function automatic int unsigned active_classes();
    return (class_count_reg > MAX_SMALL_CLASSES) ? MAX_SMALL_CLASSES : class_count_reg;
  endfunction

  function automatic response_t predict_response(request_t r);
    int unsigned n, rounded, cls, slot, word, region;
    response_t   rsp;
    rsp.status = ST_OK;
    rsp.addr   = '0;
    n = active_classes();
    if (r.kind == REQ_ALLOC) begin
      rounded = (32'(r.size) + 32'd7) & ~32'd7;
      if (rounded == 0 || rounded > MAX_BLOCK_BYTES) begin
        rsp.status = ST_BAD_SIZE;
      end else begin
        if (rounded > n * 8) begin
          cls  = n;
          slot = MAX_BLOCK_BYTES;
        end else begin
          cls  = rounded / 8 - 1;
          slot = rounded;
        end
        if (free_valid[cls]) begin
          rsp.addr        = free_top[cls];
          word            = free_top[cls] >> 3;
          free_top[cls]   = link_word[word][ADDR_W-1:0];
          free_valid[cls] = link_word[word][ADDR_W];
        end else if (region_fill[cls] + slot > REGION_BYTES) begin
          rsp.status = ST_EXHAUSTED;
        end else begin
          rsp.addr         = ADDR_W'(cls * REGION_BYTES + region_fill[cls]);
          region_fill[cls] = region_fill[cls] + slot;
        end
      end
    end else if (r.addr >= POOL_BYTES) begin
      rsp.status = ST_BAD_ADDR;
    end else begin
      region             = r.addr / REGION_BYTES;
      word               = r.addr >> 3;
      link_word[word]    = {free_valid[region], free_top[region]};
      free_top[region]   = r.addr;
      free_valid[region] = 1'b1;
    end
    return rsp;
  endfunction

  // Driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!start || req_fire) begin
      if (req_fire)
        gap_left = no_gap_run ? 0 : $urandom_range(0, 4);
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        next_req = pending_requests.pop_front();
        req_type      <= next_req.kind;
        req_size      <= next_req.size;
        block_address <= next_req.addr;
        start         <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor and predictor: everything sampled on the rising edge
  always @(posedge clk) begin
    response_t exp_rsp;
    request_t  taken_req;
    req_fire = !rst && start && !busy;
    if (!rst && done) begin
      if (expected_responses.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual status %0d addr %0d",
                 $time, status, granted_address);
      end else begin
        exp_rsp = expected_responses.pop_front();
        if (status !== exp_rsp.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d actual %0d", $time,
                   exp_rsp.status, status);
        end
        if (granted_address !== exp_rsp.addr) begin
          errors++;
          $display("%0t: granted_address mismatch: expected %0d actual %0d", $time,
                   exp_rsp.addr, granted_address);
        end
        case (exp_rsp.status)
          ST_OK:        ;
          ST_BAD_SIZE:  n_bad_size++;
          ST_EXHAUSTED: n_exhausted++;
          default:      n_bad_addr++;
        endcase
      end
    end
    if (!rst && cfg_valid && cfg_ready) begin
      class_count_reg = cfg_data;
      cfg_writes++;
    end
    if (req_fire) begin
      requests_taken++;
      taken_req.kind = req_type;
      taken_req.size = req_size;
      taken_req.addr = block_address;
      exp_rsp = predict_response(taken_req);
      if (req_type == REQ_FREE && exp_rsp.status == ST_OK)
        n_frees++;
      if (req_type == REQ_ALLOC && exp_rsp.status == ST_OK) begin
        n_grants++;
        live_blocks.push_back(exp_rsp.addr);
      end
      expected_responses.push_back(exp_rsp);
    end
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_responses.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_request(input logic kind, input int unsigned size,
                              input int unsigned addr);
    request_t r;
    r.kind = kind;
    r.size = SIZE_W'(size);
    r.addr = ADDR_W'(addr);
    pending_requests.push_back(r);
    requests_queued++;
  endtask

  task automatic queue_random_request();
    int unsigned n, pick, sz, idx;
    n    = active_classes();
    pick = $urandom_range(0, 99);
    while (pending_requests.size() >= 4)
      @(negedge clk);
    if (pick >= 50 && pick < 80 && live_blocks.size() == 0)
      pick = 0;
    if (pick < 50) begin
      if (n > 0 && $urandom_range(0, 9) < 7)
        sz = $urandom_range(1, 8 * n);
      else
        sz = $urandom_range(8 * n + 1, MAX_BLOCK_BYTES);
      push_request(REQ_ALLOC, sz, $urandom_range(0, (1 << ADDR_W) - 1));
    end else if (pick < 80) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      push_request(REQ_FREE, $urandom_range(0, (1 << SIZE_W) - 1), live_blocks[idx]);
      live_blocks.delete(idx);
    end else if (pick < 83) begin
      push_request(REQ_FREE, $urandom_range(0, (1 << SIZE_W) - 1),
                   $urandom_range(0, POOL_BYTES - 1));
    end else if (pick < 90) begin
      push_request(REQ_FREE, $urandom_range(0, (1 << SIZE_W) - 1),
                   $urandom_range(POOL_BYTES, (1 << ADDR_W) - 1));
    end else if (pick < 95) begin
      sz = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_BLOCK_BYTES + 1, 65535);
      push_request(REQ_ALLOC, sz, $urandom_range(0, (1 << ADDR_W) - 1));
    end else begin
      push_request(REQ_ALLOC, $urandom_range(0, 65535), $urandom_range(0, (1 << ADDR_W) - 1));
    end
  endtask

  task automatic wait_quiet();
    while (requests_taken != requests_queued || expected_responses.size() > 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_class_count(input logic [CFG_W-1:0] value);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    while (cfg_writes == seen)
      @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] class_settings [7];
    class_settings = '{CFG_W'(1), CFG_W'(0), CFG_W'(32), CFG_W'(63), CFG_W'(20),
                       CFG_W'($urandom_range(0, 63)), CFG_W'(8)};
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed requests at the reset class count
    push_request(REQ_ALLOC, 0, 0);
    push_request(REQ_ALLOC, 1, (1 << ADDR_W) - 1);
    push_request(REQ_ALLOC, 8, 0);
    push_request(REQ_ALLOC, 9, 0);
    push_request(REQ_ALLOC, 64, 0);
    push_request(REQ_ALLOC, 56, 0);
    push_request(REQ_ALLOC, 65, 0);
    push_request(REQ_ALLOC, MAX_BLOCK_BYTES, 0);
    push_request(REQ_ALLOC, 2041, 0);
    push_request(REQ_ALLOC, MAX_BLOCK_BYTES + 1, 0);
    push_request(REQ_ALLOC, 65535, (1 << ADDR_W) - 1);
    push_request(REQ_FREE, 65535, 0);
    push_request(REQ_ALLOC, 5, 0);
    push_request(REQ_FREE, 0, POOL_BYTES);
    push_request(REQ_FREE, 0, (1 << ADDR_W) - 1);
    push_request(REQ_FREE, 0, REGION_BYTES + 1);
    push_request(REQ_ALLOC, 16, 0);
    push_request(REQ_FREE, 0, 20 * REGION_BYTES);
    push_request(REQ_FREE, 0, POOL_BYTES - 1);
    push_request(REQ_FREE, 0, 32 * REGION_BYTES + 8);
    push_request(REQ_FREE, 0, 32 * REGION_BYTES + 8);
    push_request(REQ_FREE, 0, 8);
    push_request(REQ_ALLOC, 3, 0);

    for (int i = 0; i < PHASE_REQUESTS; i++) begin
      if (i % 50 == 0)
        no_gap_run = ($urandom_range(0, 3) == 0);
      queue_random_request();
    end
    wait_quiet();

    foreach (class_settings[p]) begin
      write_class_count(class_settings[p]);
      repeat (2) @(negedge clk);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        if (i % 50 == 0)
          no_gap_run = ($urandom_range(0, 3) == 0);
        queue_random_request();
      end
      wait_quiet();
    end

    repeat (10) @(negedge clk);
    $display("Ran %0d requests over %0d class-count settings", requests_taken, cfg_writes + 1);
    $display("Grants %0d, frees %0d, bad sizes %0d, exhausted %0d, out-of-pool frees %0d",
             n_grants, n_frees, n_bad_size, n_exhausted, n_bad_addr);
    if (errors == 0 && expected_responses.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/scba_pkg.sv
rtl/scba_front.sv
rtl/scba_queue.sv
rtl/scba_back.sv
rtl/size_class_block_allocator.sv
verif/testbench.sv
